// ----- rtl/core/sbgc_pkg.sv -----
`timescale 1ns / 1ps
package sbgc_pkg;

    localparam int DEF_MAX_BODIES = 16;
    localparam logic [31:0] ONE_UNIT = 32'h0001_0000;
    localparam logic [15:0] DT_RESET = 16'd1092;
    localparam int IN_DATA_W  = 264;
    localparam int OUT_DATA_W = 200;
    localparam int DIV_STEPS  = 33;

    // item commands
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // result status
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // register indexes
    localparam logic [2:0] REG_GRAV_X = 3'd0;
    localparam logic [2:0] REG_GRAV_Y = 3'd1;
    localparam logic [2:0] REG_GRAV_Z = 3'd2;
    localparam logic [2:0] REG_DT     = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;

    // datapath operations
    localparam logic [4:0] OP_NONE    = 5'd0;
    localparam logic [4:0] OP_CAPT    = 5'd1;
    localparam logic [4:0] OP_LOAD    = 5'd2;
    localparam logic [4:0] OP_RD_SELF = 5'd3;
    localparam logic [4:0] OP_LATCH   = 5'd4;
    localparam logic [4:0] OP_ADD_V   = 5'd5;
    localparam logic [4:0] OP_ADD_P   = 5'd6;
    localparam logic [4:0] OP_RD_J    = 5'd7;
    localparam logic [4:0] OP_ACC_SET = 5'd8;
    localparam logic [4:0] OP_ACC_ADD = 5'd9;
    localparam logic [4:0] OP_TEST    = 5'd10;
    localparam logic [4:0] OP_DIV_A   = 5'd11;
    localparam logic [4:0] OP_SAVE_A  = 5'd12;
    localparam logic [4:0] OP_DIV_B   = 5'd13;
    localparam logic [4:0] OP_BOUNCE  = 5'd14;
    localparam logic [4:0] OP_HIT     = 5'd15;
    localparam logic [4:0] OP_J_NEXT  = 5'd16;
    localparam logic [4:0] OP_WB      = 5'd17;
    localparam logic [4:0] OP_RES     = 5'd18;

    // multiplier operand selects
    localparam logic [2:0] MUL_GDT  = 3'd0;
    localparam logic [2:0] MUL_VDT  = 3'd1;
    localparam logic [2:0] MUL_DIST = 3'd2;
    localparam logic [2:0] MUL_RAD  = 3'd3;
    localparam logic [2:0] MUL_VDM  = 3'd4;
    localparam logic [2:0] MUL_WMJ  = 3'd5;

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] mul;
        logic [1:0] comp;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       live;
        logic       j_end;
        logic       j_self;
        logic       touch;
        logic       div_busy;
        logic       out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/sbgc_ctrl.sv -----
`timescale 1ns / 1ps
module sbgc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  sbgc_pkg::dp_stat_t stat,
    output sbgc_pkg::dp_cmd_t  cmd
);
    import sbgc_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DEC   = 5'd1;
    localparam logic [4:0] S_LATCH = 5'd2;
    localparam logic [4:0] S_GM    = 5'd3;
    localparam logic [4:0] S_GA    = 5'd4;
    localparam logic [4:0] S_PM    = 5'd5;
    localparam logic [4:0] S_PA    = 5'd6;
    localparam logic [4:0] S_LOOP  = 5'd7;
    localparam logic [4:0] S_DX    = 5'd8;
    localparam logic [4:0] S_DY    = 5'd9;
    localparam logic [4:0] S_DZ    = 5'd10;
    localparam logic [4:0] S_DR    = 5'd11;
    localparam logic [4:0] S_CMP   = 5'd12;
    localparam logic [4:0] S_TEST  = 5'd13;
    localparam logic [4:0] S_BA    = 5'd14;
    localparam logic [4:0] S_BA2   = 5'd15;
    localparam logic [4:0] S_BAW   = 5'd16;
    localparam logic [4:0] S_BB    = 5'd17;
    localparam logic [4:0] S_BB2   = 5'd18;
    localparam logic [4:0] S_BBW   = 5'd19;
    localparam logic [4:0] S_HIT   = 5'd20;
    localparam logic [4:0] S_WB    = 5'd21;
    localparam logic [4:0] S_RES   = 5'd22;

    localparam logic [1:0] LAST_COMP = 2'd2;

    logic [4:0] state_reg, state_next;
    logic [1:0] comp_reg, comp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            comp_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        comp_next  = comp_reg;
        cmd.op     = OP_NONE;
        cmd.mul    = MUL_GDT;
        cmd.comp   = comp_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_CAPT;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (stat.cmd == CMD_LOAD) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_RES;
                end else begin
                    cmd.op     = OP_RD_SELF;
                    state_next = S_LATCH;
                end
            end
            S_LATCH: begin
                cmd.op    = OP_LATCH;
                comp_next = 2'd0;
                if (stat.cmd == CMD_STEP && stat.live) state_next = S_GM;
                else state_next = S_RES;
            end
            S_GM: begin
                cmd.mul    = MUL_GDT;
                state_next = S_GA;
            end
            S_GA: begin
                cmd.op = OP_ADD_V;
                if (comp_reg == LAST_COMP) begin
                    comp_next  = 2'd0;
                    state_next = S_PM;
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_GM;
                end
            end
            S_PM: begin
                cmd.mul    = MUL_VDT;
                state_next = S_PA;
            end
            S_PA: begin
                cmd.op = OP_ADD_P;
                if (comp_reg == LAST_COMP) begin
                    comp_next  = 2'd0;
                    state_next = S_LOOP;
                end else begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_PM;
                end
            end
            S_LOOP: begin
                if (stat.j_end) begin
                    state_next = S_WB;
                end else if (stat.j_self) begin
                    cmd.op = OP_J_NEXT;
                end else begin
                    cmd.op     = OP_RD_J;
                    state_next = S_DX;
                end
            end
            S_DX: begin
                cmd.mul    = MUL_DIST;
                cmd.comp   = 2'd0;
                state_next = S_DY;
            end
            S_DY: begin
                cmd.mul    = MUL_DIST;
                cmd.comp   = 2'd1;
                cmd.op     = OP_ACC_SET;
                state_next = S_DZ;
            end
            S_DZ: begin
                cmd.mul    = MUL_DIST;
                cmd.comp   = 2'd2;
                cmd.op     = OP_ACC_ADD;
                state_next = S_DR;
            end
            S_DR: begin
                cmd.mul    = MUL_RAD;
                cmd.op     = OP_ACC_ADD;
                state_next = S_CMP;
            end
            S_CMP: begin
                cmd.op     = OP_TEST;
                state_next = S_TEST;
            end
            S_TEST: begin
                if (stat.touch) begin
                    comp_next  = 2'd0;
                    state_next = S_BA;
                end else begin
                    cmd.op     = OP_J_NEXT;
                    state_next = S_LOOP;
                end
            end
            S_BA: begin
                cmd.mul    = MUL_VDM;
                state_next = S_BA2;
            end
            S_BA2: begin
                cmd.op     = OP_DIV_A;
                state_next = S_BAW;
            end
            S_BAW: begin
                if (!stat.div_busy) begin
                    cmd.op     = OP_SAVE_A;
                    state_next = S_BB;
                end
            end
            S_BB: begin
                cmd.mul    = MUL_WMJ;
                state_next = S_BB2;
            end
            S_BB2: begin
                cmd.op     = OP_DIV_B;
                state_next = S_BBW;
            end
            S_BBW: begin
                if (!stat.div_busy) begin
                    cmd.op = OP_BOUNCE;
                    if (comp_reg == LAST_COMP) begin
                        state_next = S_HIT;
                    end else begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = S_BA;
                    end
                end
            end
            S_HIT: begin
                cmd.op     = OP_HIT;
                state_next = S_LOOP;
            end
            S_WB: begin
                cmd.op     = OP_WB;
                state_next = S_RES;
            end
            S_RES: begin
                if (stat.out_free) begin
                    cmd.op     = OP_RES;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ----- rtl/core/sbgc_dpath.sv -----
`timescale 1ns / 1ps
module sbgc_dpath #(
    parameter int MAX_BODIES = sbgc_pkg::DEF_MAX_BODIES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [2:0]                       cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic [sbgc_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [1:0]                       s_tuser,
    output logic [sbgc_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [1:0]                       m_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  sbgc_pkg::dp_cmd_t                cmd,
    output sbgc_pkg::dp_stat_t               stat
);
    import sbgc_pkg::*;

    localparam int AW    = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CW    = $clog2(MAX_BODIES + 1);
    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [31:0]      mass;
        logic [31:0]      radius;
    } row_t;

    localparam row_t RESET_ROW = '{pos: '0, vel: '0, mass: ONE_UNIT, radius: '0};
    localparam int ROW_W = $bits(row_t);

    function automatic logic [31:0] mag32(input logic [31:0] x);
        mag32 = x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic over34(input logic [33:0] x);
        over34 = !(x[33:31] == 3'b000 || x[33:31] == 3'b111);
    endfunction

    function automatic logic [31:0] sat34(input logic [33:0] x);
        if (!over34(x)) sat34 = x[31:0];
        else if (x[33]) sat34 = 32'h8000_0000;
        else sat34 = 32'h7fff_ffff;
    endfunction

    // configuration
    logic [2:0][31:0] grav_reg;
    logic [15:0]      dt_reg;
    logic [4:0]       count_reg;

    // captured item
    logic [1:0]       in_cmd_reg;
    logic [3:0]       in_idx_reg;
    row_t             in_row_reg;
    row_t             s_row;

    // body table
    logic [ROW_W-1:0]      mem [MAX_BODIES];
    logic [MAX_BODIES-1:0] valid_reg;
    row_t                  rd_reg;
    logic                  rdv_reg;

    // working entry and arithmetic
    row_t          cur_reg;
    logic [63:0]   prod_reg;
    logic          mneg_reg;
    logic [65:0]   acc_reg;
    logic          touch_reg;
    logic [32:0]   rem_reg;
    logic [32:0]   q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic          dneg_reg;
    logic [33:0]   qa_reg;
    logic [CW-1:0] j_reg;
    logic [3:0]    hits_reg;
    logic          sat_reg;
    logic          bad_reg;

    // result register
    logic [3:0]       out_idx_reg;
    logic [2:0][31:0] out_pos_reg;
    logic [2:0][31:0] out_vel_reg;
    logic [3:0]       out_hits_reg;
    logic [1:0]       out_st_reg;
    logic             mvalid_reg;

    logic [CW-1:0] live;
    logic          idx_live, in_store;
    logic [AW-1:0] self_addr, raddr;
    row_t          pr, lrow, wdata;
    logic          mem_we, mem_re;

    logic [31:0] mul_a, mul_b;
    logic        mul_neg;
    logic [32:0] dist_d, dist_m, rsum, msum;
    logic [31:0] mdiff;
    logic        mi_lt;
    logic [31:0] sc_mag;
    logic [33:0] sc_val, v_sum, p_sum, q_sgn, b_sum;
    logic [65:0] rsq;
    logic [33:0] rem2;
    logic        ge;
    logic [64:0] num_a, num_b;

    always_comb begin
        s_row = '0;
        for (int k = 0; k < 3; k++) begin
            s_row.pos[k] = s_tdata[4 + 32 * k +: 32];
            s_row.vel[k] = s_tdata[100 + 32 * k +: 32];
        end
        s_row.mass   = s_tdata[227:196];
        s_row.radius = s_tdata[259:228];
    end

    always_comb begin
        if (int'(count_reg) > MAX_BODIES) live = CW'(MAX_BODIES);
        else live = CW'(count_reg);
    end

    assign idx_live  = int'(in_idx_reg) < int'(live);
    assign in_store  = int'(in_idx_reg) < MAX_BODIES;
    assign self_addr = AW'(in_idx_reg);
    assign pr        = rdv_reg ? rd_reg : RESET_ROW;

    always_comb begin
        lrow = in_row_reg;
        if (lrow.mass == 32'd0) lrow.mass = 32'd1;
    end

    assign mem_we = (cmd.op == OP_LOAD && in_store) || cmd.op == OP_WB;
    assign wdata  = (cmd.op == OP_LOAD) ? lrow : cur_reg;
    assign mem_re = (cmd.op == OP_RD_SELF) || (cmd.op == OP_RD_J);
    assign raddr  = (cmd.op == OP_RD_J) ? j_reg[AW-1:0] : self_addr;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[self_addr] <= wdata;
        if (mem_re) begin
            rd_reg  <= mem[raddr];
            rdv_reg <= valid_reg[raddr];
        end
    end

    // multiplier operands
    always_comb begin
        rsum   = {1'b0, cur_reg.radius} + {1'b0, pr.radius};
        msum   = {1'b0, cur_reg.mass} + {1'b0, pr.mass};
        mi_lt  = cur_reg.mass < pr.mass;
        mdiff  = mi_lt ? (pr.mass - cur_reg.mass) : (cur_reg.mass - pr.mass);
        dist_d = {cur_reg.pos[cmd.comp][31], cur_reg.pos[cmd.comp]}
               - {pr.pos[cmd.comp][31], pr.pos[cmd.comp]};
        dist_m = dist_d[32] ? (~dist_d + 33'd1) : dist_d;
        case (cmd.mul)
            MUL_GDT: begin
                mul_a   = mag32(grav_reg[cmd.comp]);
                mul_b   = {16'd0, dt_reg};
                mul_neg = grav_reg[cmd.comp][31];
            end
            MUL_VDT: begin
                mul_a   = mag32(cur_reg.vel[cmd.comp]);
                mul_b   = {16'd0, dt_reg};
                mul_neg = cur_reg.vel[cmd.comp][31];
            end
            MUL_DIST: begin
                mul_a   = dist_m[31:0];
                mul_b   = dist_m[31:0];
                mul_neg = 1'b0;
            end
            MUL_RAD: begin
                mul_a   = rsum[31:0];
                mul_b   = rsum[31:0];
                mul_neg = 1'b0;
            end
            MUL_VDM: begin
                mul_a   = mag32(cur_reg.vel[cmd.comp]);
                mul_b   = mdiff;
                mul_neg = cur_reg.vel[cmd.comp][31] ^ mi_lt;
            end
            MUL_WMJ: begin
                mul_a   = mag32(pr.vel[cmd.comp]);
                mul_b   = pr.mass;
                mul_neg = pr.vel[cmd.comp][31];
            end
            default: begin
                mul_a   = 32'd0;
                mul_b   = 32'd0;
                mul_neg = 1'b0;
            end
        endcase
    end

    // product times dt, floor toward minus infinity
    always_comb begin
        sc_mag = mneg_reg ? 32'((prod_reg + 64'd65535) >> 16) : 32'(prod_reg >> 16);
        sc_val = mneg_reg ? (34'd0 - {2'b00, sc_mag}) : {2'b00, sc_mag};
        v_sum  = {{2{cur_reg.vel[cmd.comp][31]}}, cur_reg.vel[cmd.comp]} + sc_val;
        p_sum  = {{2{cur_reg.pos[cmd.comp][31]}}, cur_reg.pos[cmd.comp]} + sc_val;
    end

    // (ri+rj)^2 from the low-word square plus the carry-bit terms
    assign rsq = {2'b00, prod_reg}
               + (rsum[32] ? ({1'b0, rsum[31:0], 33'd0} + (66'd1 << 64)) : 66'd0);

    // restoring divider, quotient known to fit 33 bits
    assign num_a = {1'b0, prod_reg};
    assign num_b = {prod_reg, 1'b0};
    assign rem2  = {rem_reg, q_reg[32]};
    assign ge    = rem2 >= {1'b0, msum};
    assign q_sgn = dneg_reg ? (34'd0 - {1'b0, q_reg}) : {1'b0, q_reg};
    assign b_sum = qa_reg + q_sgn;

    // configuration and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg   <= '0;
            dt_reg     <= DT_RESET;
            count_reg  <= 5'd0;
            valid_reg  <= '0;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GRAV_X: grav_reg[0] <= cfg_data;
                    REG_GRAV_Y: grav_reg[1] <= cfg_data;
                    REG_GRAV_Z: grav_reg[2] <= cfg_data;
                    REG_DT:     dt_reg      <= cfg_data[15:0];
                    REG_COUNT:  count_reg   <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (mem_we) valid_reg[self_addr] <= 1'b1;
            if (cmd.op == OP_DIV_A || cmd.op == OP_DIV_B) cnt_reg <= CNT_W'(DIV_STEPS);
            else if (cnt_reg != '0) cnt_reg <= cnt_reg - 1'b1;
            if (cmd.op == OP_RES) mvalid_reg <= 1'b1;
            else if (m_tready) mvalid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        mneg_reg <= mul_neg;
        if (cnt_reg != '0) begin
            rem_reg <= ge ? 33'(rem2 - {1'b0, msum}) : rem2[32:0];
            q_reg   <= {q_reg[31:0], ge};
        end
        case (cmd.op)
            OP_CAPT: begin
                in_cmd_reg <= s_tuser;
                in_idx_reg <= s_tdata[3:0];
                in_row_reg <= s_row;
            end
            OP_LOAD: begin
                cur_reg  <= in_store ? lrow : '0;
                hits_reg <= 4'd0;
                sat_reg  <= 1'b0;
                bad_reg  <= !in_store;
            end
            OP_LATCH: begin
                cur_reg  <= in_store ? pr : '0;
                hits_reg <= 4'd0;
                sat_reg  <= 1'b0;
                bad_reg  <= !idx_live;
                j_reg    <= '0;
            end
            OP_ADD_V: begin
                cur_reg.vel[cmd.comp] <= sat34(v_sum);
                if (over34(v_sum)) sat_reg <= 1'b1;
            end
            OP_ADD_P: begin
                cur_reg.pos[cmd.comp] <= sat34(p_sum);
                if (over34(p_sum)) sat_reg <= 1'b1;
            end
            OP_ACC_SET: acc_reg <= {2'b00, prod_reg};
            OP_ACC_ADD: acc_reg <= acc_reg + {2'b00, prod_reg};
            OP_TEST:    touch_reg <= (acc_reg <= rsq);
            OP_DIV_A: begin
                rem_reg  <= {1'b0, num_a[64:33]};
                q_reg    <= num_a[32:0];
                dneg_reg <= mneg_reg;
            end
            OP_DIV_B: begin
                rem_reg  <= {1'b0, num_b[64:33]};
                q_reg    <= num_b[32:0];
                dneg_reg <= mneg_reg;
            end
            OP_SAVE_A: qa_reg <= q_sgn;
            OP_BOUNCE: begin
                cur_reg.vel[cmd.comp] <= sat34(b_sum);
                if (over34(b_sum)) sat_reg <= 1'b1;
            end
            OP_HIT: begin
                if (hits_reg != 4'hf) hits_reg <= hits_reg + 4'd1;
                j_reg <= j_reg + 1'b1;
            end
            OP_J_NEXT: j_reg <= j_reg + 1'b1;
            OP_RES: begin
                out_idx_reg  <= in_idx_reg;
                out_pos_reg  <= cur_reg.pos;
                out_vel_reg  <= cur_reg.vel;
                out_hits_reg <= hits_reg;
                out_st_reg   <= bad_reg ? ST_BAD : (sat_reg ? ST_SAT : ST_OK);
            end
            default: ;
        endcase
    end

    assign m_tdata  = {out_hits_reg, out_vel_reg, out_pos_reg, out_idx_reg};
    assign m_tuser  = out_st_reg;
    assign m_tvalid = mvalid_reg;

    assign stat.cmd      = in_cmd_reg;
    assign stat.live     = idx_live;
    assign stat.j_end    = j_reg >= live;
    assign stat.j_self   = int'(j_reg) == int'(in_idx_reg);
    assign stat.touch    = touch_reg;
    assign stat.div_busy = cnt_reg != '0;
    assign stat.out_free = !mvalid_reg || m_tready;

endmodule

// ----- rtl/core/sphere_body_gravity_collision_step.sv -----
`timescale 1ns / 1ps
// one item at a time; a load passes capture, decode and result before m_tvalid rises,
// a read also passes the latch state; a step's run time is set by the shared 32x32 multiplier
// and the 33-step bit-serial divider (6 divides per touch)
// next item is taken once the result sits in the output register
// reset (aresetn low, synchronous) restores register defaults and clears the
// entry valid bits, so every body reads as zero with unit mass; no clearing pass
module sphere_body_gravity_collision_step #(
    parameter int MAX_BODIES = sbgc_pkg::DEF_MAX_BODIES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // register write port
    input  logic                             cfg_wr_en,
    input  logic [2:0]                       cfg_index,
    input  logic [31:0]                      cfg_data,
    // item input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // body_index, load_pos_x/y/z, load_vel_x/y/z, load_mass, load_radius, pad
    input  logic [sbgc_pkg::IN_DATA_W-1:0]   s_tdata,
    // cmd
    input  logic [1:0]                       s_tuser,
    // result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_index, out_pos_x/y/z, out_vel_x/y/z, hit_count
    output logic [sbgc_pkg::OUT_DATA_W-1:0]  m_tdata,
    // status
    output logic [1:0]                       m_tuser
);
    import sbgc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: walks the step stages and the pair loop
    sbgc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // body table, multiplier, divider and result register
    sbgc_dpath #(
        .MAX_BODIES (MAX_BODIES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // divider never left running while waiting for an item
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !stat.div_busy)
        else $error("divider busy while idle");

    // a rejected index never reports touches
    a_bad_nohits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_BAD) |-> (m_tdata[199:196] == 4'd0))
        else $error("hits on rejected item");

    // an accepted item keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted two items back to back");

endmodule
